// ===== rtl/flf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_pkg
// Shared constants, register codes, state types and the line job type for
// the line folder with tab expansion.
// ----------------------------------------------------------------------------
package flf_pkg;

  localparam int MAX_LINE_DEF = 63;

  // count width: fill count, positions and line lengths for any MAX_LINE in 2..63
  localparam int CNT_W = 6;
  localparam int LW_W  = 6;
  localparam int TW_W  = 5;
  localparam int CFG_W = 6;

  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;

  localparam logic [LW_W-1:0] LW_RESET = 6'd20;
  localparam logic [LW_W-1:0] LW_MIN   = 6'd2;
  localparam logic [TW_W-1:0] TW_RESET = 5'd8;
  localparam logic [TW_W-1:0] TW_MIN   = 5'd1;

  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_TAB_WIDTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    F_IDLE,
    F_TAB
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_CHARS
  } back_state_t;

  // one emitted line: len stored characters, then a newline
  typedef struct packed {
    logic [CNT_W-1:0] len;
  } line_job_t;

endpackage

// ===== rtl/flf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module flf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/flf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_front
// Accepts characters, expands tabs into the line store, tracks the fill
// count and the rightmost space, and decides where each line folds. Every
// fold or newline becomes one line job for the back end.
// ----------------------------------------------------------------------------
module flf_front #(
  parameter int MAX_LINE = flf_pkg::MAX_LINE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [flf_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_char,
  output logic                                 jq_push,
  output flf_pkg::line_job_t                   jq_job,
  input  logic                                 jq_full,
  input  logic                                 rd_take,
  output logic                                 wr_en,
  output logic [$clog2(MAX_LINE+1)-1:0]        wr_addr,
  output logic [7:0]                           wr_data
);
  import flf_pkg::*;

  localparam int AW    = $clog2(MAX_LINE + 1);
  localparam int DEPTH = 1 << AW;

  front_state_t     fst_r, fst_nxt;
  logic [LW_W-1:0]  cfg_lw_r;
  logic [TW_W-1:0]  cfg_tw_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] ls_r, ls_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [CNT_W:0]   pend_r, pend_nxt;

  logic [CNT_W-1:0] lw_eff, w_col, tend, land_pos, job_len;
  logic [TW_W-1:0]  tw_eff;
  logic [CNT_W:0]   tsum;
  logic [CNT_W+1:0] room_fill, room_cur;
  logic             can_wr, tab_ok, acc, land_go, land_sp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lw_r <= LW_RESET;
      cfg_tw_r <= TW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: cfg_lw_r <= cfg_data[LW_W-1:0];
        REG_TAB_WIDTH:  cfg_tw_r <= cfg_data[TW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_lw_r < LW_MIN) begin
      lw_eff = CNT_W'(LW_MIN);
    end else if (int'(cfg_lw_r) > MAX_LINE) begin
      lw_eff = CNT_W'(MAX_LINE);
    end else begin
      lw_eff = CNT_W'(cfg_lw_r);
    end
    tw_eff = (cfg_tw_r < TW_MIN) ? TW_MIN : cfg_tw_r;
    // an overlong line folds where the next character lands
    w_col  = (fill_r > lw_eff) ? fill_r : lw_eff;
    tsum   = {1'b0, fill_r} + {{(CNT_W + 1 - TW_W){1'b0}}, tw_eff} - (CNT_W+1)'(1);
    tend   = (tsum > {1'b0, w_col}) ? w_col : tsum[CNT_W-1:0];
  end

  // unread job characters plus the live line must fit in the store
  assign room_fill = {1'b0, pend_r} + {2'b0, fill_r};
  assign room_cur  = {1'b0, pend_r} + {2'b0, cur_r};
  assign can_wr    = int'(room_fill) <= DEPTH - 1;
  assign tab_ok    = int'(room_cur) <= DEPTH - 1;

  assign in_ready = (fst_r == F_IDLE) && !jq_full && can_wr;
  assign acc      = in_valid && in_ready;

  always_comb begin
    fst_nxt  = fst_r;
    fill_nxt = fill_r;
    ls_nxt   = ls_r;
    cur_nxt  = cur_r;
    end_nxt  = end_r;
    base_nxt = base_r;
    wr_en    = 1'b0;
    wr_addr  = base_r + AW'(fill_r);
    wr_data  = CH_SP;
    jq_push  = 1'b0;
    job_len  = '0;
    land_go  = 1'b0;
    land_pos = fill_r;
    land_sp  = 1'b0;

    case (fst_r)
      F_IDLE: begin
        if (acc) begin
          case (in_char)
            CH_NL: begin
              jq_push  = 1'b1;
              job_len  = fill_r;
              fill_nxt = '0;
              ls_nxt   = '0;
            end
            CH_TAB: begin
              wr_en = 1'b1;
              if (tend == fill_r) begin
                land_go = 1'b1;
                land_sp = 1'b1;
              end else begin
                cur_nxt = fill_r + CNT_W'(1);
                end_nxt = tend;
                fst_nxt = F_TAB;
              end
            end
            default: begin
              wr_en   = 1'b1;
              wr_data = in_char;
              land_go = 1'b1;
              land_sp = (in_char == CH_SP);
            end
          endcase
        end
      end
      F_TAB: begin
        wr_addr = base_r + AW'(cur_r);
        if (tab_ok) begin
          wr_en = 1'b1;
          if (cur_r == end_r) begin
            land_go  = 1'b1;
            land_pos = cur_r;
            land_sp  = 1'b1;
            fst_nxt  = F_IDLE;
          end else begin
            cur_nxt = cur_r + CNT_W'(1);
          end
        end
      end
      default: fst_nxt = F_IDLE;
    endcase

    if (land_go) begin
      if (land_pos == w_col) begin
        // fold: break after the rightmost space unless the landing char is one or there is none
        jq_push = 1'b1;
        if (!land_sp && ls_r != '0) begin
          job_len  = ls_r + CNT_W'(1);
          fill_nxt = land_pos - ls_r;
        end else begin
          job_len  = land_pos;
          fill_nxt = CNT_W'(1);
        end
        ls_nxt = '0;
      end else begin
        fill_nxt = land_pos + CNT_W'(1);
        if (land_sp && land_pos != '0) begin
          ls_nxt = land_pos;
        end
      end
    end

    // the next line starts right after the emitted characters
    if (jq_push) begin
      base_nxt = base_r + AW'(job_len);
    end
    pend_nxt = pend_r - {{CNT_W{1'b0}}, rd_take}
             + (jq_push ? {1'b0, job_len} : '0);
  end

  assign jq_job.len = job_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r  <= F_IDLE;
      fill_r <= '0;
      ls_r   <= '0;
      base_r <= '0;
      pend_r <= '0;
    end else begin
      fst_r  <= fst_nxt;
      fill_r <= fill_nxt;
      ls_r   <= ls_nxt;
      base_r <= base_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    end_r <= end_nxt;
  end

`ifndef SYNTHESIS
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    int'(room_fill) <= DEPTH)
    else $error("live line and unread characters overrun the store");
  a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
    rd_take |-> pend_r != '0)
    else $error("back end reads a character that was never handed over");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    jq_push |-> !jq_full)
    else $error("line job pushed into a full queue");
`endif

endmodule

// ===== rtl/flf_jobq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_jobq
// Two-entry queue of line jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module flf_jobq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  flf_pkg::line_job_t push_job,
  output logic               full,
  output logic               valid,
  output flf_pkg::line_job_t job,
  input  logic               pop
);
  import flf_pkg::*;

  line_job_t  slot0_r, slot1_r;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign job   = rp_r ? slot1_r : slot0_r;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wp_r) begin
      slot0_r <= push_job;
    end
    if (push && wp_r) begin
      slot1_r <= push_job;
    end
  end

endmodule

// ===== rtl/flf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flf_back
// Carries out line jobs: reads the stored characters of each line in order,
// appends the newline and presents the beats through a two-entry output
// buffer.
// ----------------------------------------------------------------------------
module flf_back #(
  parameter int MAX_LINE = flf_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          jq_valid,
  input  flf_pkg::line_job_t            jq_job,
  output logic                          jq_pop,
  output logic                          rd_take,
  output logic [$clog2(MAX_LINE+1)-1:0] rd_addr,
  input  logic [7:0]                    rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char,
  output logic                          out_last_of_run
);
  import flf_pkg::*;

  localparam int AW = $clog2(MAX_LINE + 1);

  typedef struct packed {
    logic       last;
    logic [7:0] ch;
  } out_beat_t;

  back_state_t      bst_r, bst_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    rd_r;
  logic             p_r, p_nl_r;
  out_beat_t        ent0_r, ent1_r, head, land;
  logic             wp_r, rp_r;
  logic [1:0]       occ_r;
  logic [2:0]       lvl;
  logic             pop, slot, issue_nl;

  assign pop  = out_valid && out_ready;
  assign head = rp_r ? ent1_r : ent0_r;
  // a beat issued now lands next cycle; keep the buffer from overflowing
  assign lvl  = {1'b0, occ_r} + {2'b0, p_r};
  assign slot = lvl <= ({2'b0, pop} + 3'd1);

  always_comb begin
    bst_nxt  = bst_r;
    cnt_nxt  = cnt_r;
    jq_pop   = 1'b0;
    rd_take  = 1'b0;
    issue_nl = 1'b0;
    case (bst_r)
      B_IDLE: begin
        if (slot && jq_valid) begin
          jq_pop = 1'b1;
          if (jq_job.len == '0) begin
            issue_nl = 1'b1;
          end else begin
            rd_take = 1'b1;
            cnt_nxt = jq_job.len - CNT_W'(1);
            bst_nxt = B_CHARS;
          end
        end
      end
      B_CHARS: begin
        if (slot) begin
          if (cnt_r == '0) begin
            issue_nl = 1'b1;
            bst_nxt  = B_IDLE;
          end else begin
            rd_take = 1'b1;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: bst_nxt = B_IDLE;
    endcase
  end

  assign rd_addr = rd_r;

  always_comb begin
    land.last = p_nl_r;
    land.ch   = p_nl_r ? CH_NL : rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r  <= B_IDLE;
      rd_r   <= '0;
      p_r    <= 1'b0;
      p_nl_r <= 1'b0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      occ_r  <= 2'd0;
    end else begin
      bst_r  <= bst_nxt;
      p_r    <= rd_take || issue_nl;
      p_nl_r <= issue_nl;
      if (rd_take) begin
        rd_r <= rd_r + AW'(1);
      end
      if (p_r) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      occ_r <= occ_r + {1'b0, p_r} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (p_r && !wp_r) begin
      ent0_r <= land;
    end
    if (p_r && wp_r) begin
      ent1_r <= land;
    end
  end

  assign out_valid       = (occ_r != 2'd0);
  assign out_char        = head.ch;
  assign out_last_of_run = head.last;

`ifndef SYNTHESIS
  a_buf_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == 2'd2 && !pop) |-> !p_r)
    else $error("output buffer overflow");
`endif

endmodule

// ===== rtl/line_folder_with_tab_expand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_folder_with_tab_expand
// Folds a character stream into lines of at most line_width columns,
// breaking after the rightmost space, with tabs expanded to spaces.
//
//   channel   ports                                  handshake
//   input     in_char                                in_valid / in_ready
//   output    out_char, out_last_of_run              out_valid / out_ready
//   config    cfg_index, cfg_data                    cfg_we, no wait
//
// An ordinary character or a newline is taken in a single handshake; a tab is
// expanded into spaces written one at a time through the single write port of
// the line store, and no new character is taken until it is done. The back end
// emits a line of n characters as n + 1 beats, one store read per character beat; the newline carries out_last_of_run.
// The front stalls when the two-entry job queue is full or when unread
// characters of queued lines still occupy the store slots it would write.
// Reset is synchronous and needs no clearing pass; the store is never read
// beyond what was written.
// ----------------------------------------------------------------------------
module line_folder_with_tab_expand #(
  parameter int MAX_LINE = flf_pkg::MAX_LINE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [flf_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_char,
  output logic                      out_last_of_run
);
  import flf_pkg::*;

  localparam int AW    = $clog2(MAX_LINE + 1);
  localparam int DEPTH = 1 << AW;

  logic          jq_push, jq_full, jq_valid, jq_pop;
  line_job_t     push_job, head_job;
  logic          rd_take;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  flf_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .jq_push   (jq_push),
    .jq_job    (push_job),
    .jq_full   (jq_full),
    .rd_take   (rd_take),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  flf_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (push_job),
    .full     (jq_full),
    .valid    (jq_valid),
    .job      (head_job),
    .pop      (jq_pop)
  );

  flf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_take),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  flf_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .jq_valid        (jq_valid),
    .jq_job          (head_job),
    .jq_pop          (jq_pop),
    .rd_take         (rd_take),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule
